[src/p422rgb_pkg.sv]
// Shared types, constants and helpers for the packed 4:2:2 to RGB24 converter.
// No dependencies; imported by every module of the block.
package p422rgb_pkg;

	// Byte order codes of the mode register
	localparam logic [1:0] MODE_UYVY  = 2'd0;
	localparam logic [1:0] MODE_YUYV  = 2'd1;
	localparam logic [1:0] MODE_YVYU  = 2'd2;
	localparam logic [1:0] MODE_RESET = MODE_YUYV;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned TERM_W  = 17;	// chroma products, signed
	localparam int unsigned SUM_W   = 18;	// luma*256 plus chroma term, signed

	localparam logic signed [TERM_W-1:0] COEF_RV = 17'sd359;
	localparam logic signed [TERM_W-1:0] COEF_GU = 17'sd88;
	localparam logic signed [TERM_W-1:0] COEF_GV = 17'sd183;
	localparam logic signed [TERM_W-1:0] COEF_BU = 17'sd454;

	// One pixel on its way to the matrix stage
	typedef struct packed {
		logic [BYTE_W-1:0]        luma;
		logic signed [BYTE_W-1:0] cu;
		logic signed [BYTE_W-1:0] cv;
		logic                     second;
		logic                     last;
	} pix_t;

	// Remove the 128 offset: flipping the top bit gives the signed value
	function automatic logic signed [BYTE_W-1:0] to_chroma(input logic [BYTE_W-1:0] b);
		return $signed({~b[BYTE_W-1], b[BYTE_W-2:0]});
	endfunction

	// Floor-shift by 8 and clamp to 0..255
	function automatic logic [BYTE_W-1:0] clamp_px(input logic signed [SUM_W-1:0] s);
		logic [BYTE_W-1:0] res;
		if (s[SUM_W-1]) begin
			res = '0;
		end else if (s[SUM_W-2]) begin
			res = '1;
		end else begin
			res = s[SUM_W-3:BYTE_W];
		end
		return res;
	endfunction

endpackage

[src/p422rgb_unpack.sv]
// Input register and byte-order decode, then split of each macropixel into two pixels.
// Depends on p422rgb_pkg.
module p422rgb_unpack import p422rgb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          mode,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [4*BYTE_W-1:0] in_bytes,
	input  logic                in_last,
	output logic                pix_valid,
	input  logic                pix_ready,
	output pix_t                pix
);

	logic                     valid_s1;
	logic                     phase_q;	// 0: first pixel pending, 1: second
	logic [BYTE_W-1:0]        y0_s1, y1_s1;
	logic signed [BYTE_W-1:0] cu_s1, cv_s1;
	logic                     last_s1;

	logic [BYTE_W-1:0] b0, b1, b2, b3;
	logic [BYTE_W-1:0] y0_d, y1_d, u_d, v_d;

	assign b0 = in_bytes[BYTE_W-1:0];
	assign b1 = in_bytes[2*BYTE_W-1:BYTE_W];
	assign b2 = in_bytes[3*BYTE_W-1:2*BYTE_W];
	assign b3 = in_bytes[4*BYTE_W-1:3*BYTE_W];

	always_comb begin
		unique case (mode)
			MODE_UYVY: begin
				u_d = b0; y0_d = b1; v_d = b2; y1_d = b3;
			end
			MODE_YVYU: begin
				y0_d = b0; v_d = b1; y1_d = b2; u_d = b3;
			end
			default: begin
				y0_d = b0; u_d = b1; y1_d = b2; v_d = b3;
			end
		endcase
	end

	// Take a new request when empty or once the second pixel of the held one leaves
	assign in_ready  = !valid_s1 || (phase_q && pix_ready);
	assign pix_valid = valid_s1;

	always_comb begin
		pix.luma   = phase_q ? y1_s1 : y0_s1;
		pix.cu     = cu_s1;
		pix.cv     = cv_s1;
		pix.second = phase_q;
		pix.last   = phase_q && last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			phase_q  <= 1'b0;
		end else if (pix_ready) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			y0_s1   <= y0_d;
			y1_s1   <= y1_d;
			cu_s1   <= to_chroma(u_d);
			cv_s1   <= to_chroma(v_d);
			last_s1 <= in_last;
		end
	end

endmodule

[src/p422rgb_csc.sv]
// Color matrix: chroma products in one stage, luma sum, shift and clamp in the next.
// Depends on p422rgb_pkg.
module p422rgb_csc import p422rgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  pix_t              pix,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] red,
	output logic [BYTE_W-1:0] green,
	output logic [BYTE_W-1:0] blue,
	output logic              second,
	output logic              last
);

	logic                     valid_s2, valid_s3;
	logic                     ready_s3;
	logic [BYTE_W-1:0]        luma_s2;
	logic signed [TERM_W-1:0] rt_s2, gt_s2, bt_s2;
	logic                     second_s2, last_s2;
	logic [BYTE_W-1:0]        red_s3, green_s3, blue_s3;
	logic                     second_s3, last_s3;

	logic signed [TERM_W-1:0] rt_d, gt_d, bt_d;
	logic signed [SUM_W-1:0]  ys, rs, gs, bs;

	assign ready_s3  = !valid_s3 || out_ready;
	assign pix_ready = !valid_s2 || ready_s3;

	always_comb begin
		rt_d = COEF_RV * TERM_W'(pix.cv);
		gt_d = COEF_GU * TERM_W'(pix.cu) + COEF_GV * TERM_W'(pix.cv);
		bt_d = COEF_BU * TERM_W'(pix.cu);
	end

	always_comb begin
		ys = $signed({2'b00, luma_s2, {BYTE_W{1'b0}}});
		rs = ys + SUM_W'(rt_s2);
		gs = ys - SUM_W'(gt_s2);
		bs = ys + SUM_W'(bt_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (pix_ready) begin
				valid_s2 <= pix_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid) begin
			luma_s2   <= pix.luma;
			rt_s2     <= rt_d;
			gt_s2     <= gt_d;
			bt_s2     <= bt_d;
			second_s2 <= pix.second;
			last_s2   <= pix.last;
		end
		if (ready_s3 && valid_s2) begin
			red_s3    <= clamp_px(rs);
			green_s3  <= clamp_px(gs);
			blue_s3   <= clamp_px(bs);
			second_s3 <= second_s2;
			last_s3   <= last_s2;
		end
	end

	assign out_valid = valid_s3;
	assign red       = red_s3;
	assign green     = green_s3;
	assign blue      = blue_s3;
	assign second    = second_s3;
	assign last      = last_s3;

endmodule

[src/packed_yuv422_to_rgb24.sv]
// Top level of the packed 4:2:2 YUV to RGB24 converter: mode register and pipeline.
// Depends on p422rgb_pkg, p422rgb_unpack and p422rgb_csc.
//
// Usage:
//   s_axis carries one macropixel per request: four stream bytes in tdata, tlast on
//   the last macropixel of a frame. m_axis carries one RGB pixel per request:
//   tlast marks the second pixel of a macropixel, tuser the final pixel of a frame.
//   cfg_wr_en/cfg_wr_data write the byte order (0 UYVY, 1 YUYV, 2 YVYU, 3 as YUYV);
//   write it only while the pipeline is empty.
// The first pixel of an accepted macropixel passes the input register, the product
//   register and the output register; the second pixel follows behind it.
// Throughput: one pixel per cycle while m_axis_tready stays high; the input
//   register is held while it hands out its two pixels.
// Reset clears all valid bits and sets the byte order to YUYV.
// When m_axis_tready is low the output register holds and the stall backs up
//   stage by stage to s_axis_tready; nothing is dropped or repeated.
module packed_yuv422_to_rgb24 import p422rgb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [1:0]          cfg_wr_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [4*BYTE_W-1:0] s_axis_tdata,	// byte_zero, byte_one, byte_two, byte_three
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [3*BYTE_W-1:0] m_axis_tdata,	// red, green, blue
	output logic                m_axis_tlast,
	output logic                m_axis_tuser	// frame_end_out
);

	logic [1:0]        mode_q;
	logic              pix_valid, pix_ready;
	pix_t              pix;
	logic [BYTE_W-1:0] red, green, blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	p422rgb_unpack u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_bytes  (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix)
	);

	p422rgb_csc u_csc (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.second    (m_axis_tlast),
		.last      (m_axis_tuser)
	);

	assign m_axis_tdata = {blue, green, red};

	// Frame end only rides on the second pixel
	a_fend_on_second: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("frame end on first pixel");

	// An accepted macropixel starts with its first pixel
	a_load_first: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> pix_valid && !pix.second)
		else $error("macropixel not loaded as first pixel");

	// No new macropixel while the first pixel is still pending
	a_hold_first: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix.second |-> !s_axis_tready)
		else $error("input accepted over pending pixel");

endmodule
